[rtl/core/kcre_pkg.sv]
`timescale 1ns / 1ps

package kcre_pkg;

    localparam int PIXEL_W  = 8;
    localparam int COORD_W  = 11;
    localparam int DIM_W    = 12;
    localparam int LENGTH_W = 12;
    localparam int SLOT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam int MAX_COLUMNS_DEF = 2048;
    localparam int MAX_ROWS_DEF    = 2048;

    // lowest slot index at which a run is flagged as overflow
    localparam logic [SLOT_W-1:0] RUNS_PER_ROW = SLOT_W'(5);
    localparam logic [SLOT_W-1:0] SLOT_MAX     = '1;

    localparam logic [PIXEL_W-1:0] KEY_COLOR_RST = 8'd255;
    localparam logic [DIM_W-1:0]   WIDTH_RST     = 12'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RST    = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_COLOR     = 3'd0,
        CFG_ORIGIN_X      = 3'd1,
        CFG_ORIGIN_Y      = 3'd2,
        CFG_WINDOW_WIDTH  = 3'd3,
        CFG_WINDOW_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PIXEL_W-1:0] key_color;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [DIM_W-1:0]   window_width;
        logic [DIM_W-1:0]   window_height;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic [SLOT_W-1:0]   slot;
        logic                overflow;
    } t_run;

endpackage

[rtl/core/kcre_cfg.sv]
`timescale 1ns / 1ps

module kcre_cfg
    import kcre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_COLOR:     n_cfg.key_color     = i_cfg_data[PIXEL_W-1:0];
                CFG_ORIGIN_X:      n_cfg.origin_x      = i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:      n_cfg.origin_y      = i_cfg_data[COORD_W-1:0];
                CFG_WINDOW_WIDTH:  n_cfg.window_width  = i_cfg_data[DIM_W-1:0];
                CFG_WINDOW_HEIGHT: n_cfg.window_height = i_cfg_data[DIM_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_color     <= KEY_COLOR_RST;
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.window_width  <= WIDTH_RST;
            r_cfg.window_height <= HEIGHT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/core/kcre_scan.sv]
`timescale 1ns / 1ps

module kcre_scan
    import kcre_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [PIXEL_W-1:0] i_pixel,
    input  logic               i_take,
    output logic               o_run_valid,
    output t_run               o_run
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int XCW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int YCW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

    logic               r_valid;
    logic [PIXEL_W-1:0] r_pixel;
    logic [CW-1:0]      r_col,        n_col;
    logic [RW-1:0]      r_row,        n_row;
    logic               r_in_run,     n_in_run;
    logic [CW-1:0]      r_open_start, n_open_start;
    logic [SLOT_W-1:0]  r_runs,       n_runs;

    logic               process;
    logic               key;
    logic               row_end;
    logic               last_row;
    logic [XCW-1:0]     w_last;
    logic [YCW-1:0]     h_last;
    logic               emit;
    logic [CW-1:0]      run_start;
    logic [CW:0]        run_len;

    assign process = r_valid && i_take;
    assign o_stall = r_valid && !i_take;

    // last column / row index, with zero treated as one and clamped to the limit
    always_comb begin
        if (i_cfg.window_width == '0) begin
            w_last = '0;
        end else if (XCW'(i_cfg.window_width) > XCW'(MAX_COLUMNS)) begin
            w_last = XCW'(MAX_COLUMNS - 1);
        end else begin
            w_last = XCW'(i_cfg.window_width) - XCW'(1);
        end
        if (i_cfg.window_height == '0) begin
            h_last = '0;
        end else if (YCW'(i_cfg.window_height) > YCW'(MAX_ROWS)) begin
            h_last = YCW'(MAX_ROWS - 1);
        end else begin
            h_last = YCW'(i_cfg.window_height) - YCW'(1);
        end
    end

    assign key      = (r_pixel == i_cfg.key_color);
    assign row_end  = (XCW'(r_col) >= w_last);
    assign last_row = (YCW'(r_row) >= h_last);

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_in_run     = r_in_run;
        n_open_start = r_open_start;
        n_runs       = r_runs;
        emit         = 1'b0;
        run_start    = r_open_start;
        run_len      = {1'b0, r_col} - {1'b0, r_open_start};

        if (!r_in_run) begin
            if (key) begin
                n_open_start = r_col;
                n_in_run     = 1'b1;
                run_start    = r_col;
                run_len      = (CW+1)'(1);
                emit         = row_end;
            end
        end else if (!key) begin
            n_in_run = 1'b0;
            emit     = 1'b1;
        end else if (row_end) begin
            run_len = {1'b0, r_col} - {1'b0, r_open_start} + (CW+1)'(1);
            emit    = 1'b1;
        end

        if (emit && r_runs != SLOT_MAX) begin
            n_runs = r_runs + SLOT_W'(1);
        end

        if (row_end) begin
            n_col    = '0;
            n_in_run = 1'b0;
            n_runs   = '0;
            n_row    = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    assign o_run_valid    = process && emit;
    assign o_run.row      = i_cfg.origin_y + COORD_W'(r_row);
    assign o_run.start    = i_cfg.origin_x + COORD_W'(run_start);
    assign o_run.length   = LENGTH_W'(run_len);
    assign o_run.slot     = r_runs;
    assign o_run.overflow = (r_runs >= RUNS_PER_ROW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_in_run     <= 1'b0;
            r_open_start <= '0;
            r_runs       <= '0;
        end else begin
            if (!o_stall) begin
                r_valid <= i_valid;
            end
            if (process) begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_in_run     <= n_in_run;
                r_open_start <= n_open_start;
                r_runs       <= n_runs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_pixel <= i_pixel;
        end
    end

`ifndef SYNTH
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_valid |-> run_len != '0)
        else $error("run of zero length reported");

    a_open_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> r_open_start <= r_col)
        else $error("open run starts past current column");

    a_row_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && row_end |=> !r_in_run && r_col == '0 && r_runs == '0)
        else $error("row end did not reset run tracking");
`endif

endmodule

[rtl/core/kcre_out.sv]
`timescale 1ns / 1ps

module kcre_out
    import kcre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load_valid,
    input  t_run i_load_run,
    output logic o_take,
    output logic o_valid,
    input  logic i_stall,
    output t_run o_run
);

    logic r_valid;
    t_run r_run;

    // slot is free when empty or being drained this cycle
    assign o_take  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_run   = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_load_valid) begin
            r_run <= i_load_run;
        end
    end

endmodule

[rtl/core/key_color_run_extractor.sv]
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// pixel     in   i_pixel_valid / o_pixel_stall  i_pixel
// run       out  o_run_valid / i_run_stall      o_run_row, o_run_start, o_run_length,
//                                               o_run_slot, o_run_overflow
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One pixel per clock sustained while the run output is not stalled. A pixel waits in the
// input register, and its run (if it closes one) is loaded into the output register
// that drives o_run_valid. Reset is synchronous, active low, no init pass.
// The run tracker advances only when the output register is free or draining, so a
// stalled run holds the input register; with both full, o_pixel_stall tracks i_run_stall.
module key_color_run_extractor
    import kcre_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pixel_valid,
    output logic                  o_pixel_stall,
    input  logic [PIXEL_W-1:0]    i_pixel,
    output logic                  o_run_valid,
    input  logic                  i_run_stall,
    output logic [COORD_W-1:0]    o_run_row,
    output logic [COORD_W-1:0]    o_run_start,
    output logic [LENGTH_W-1:0]   o_run_length,
    output logic [SLOT_W-1:0]     o_run_slot,
    output logic                  o_run_overflow
);

    t_cfg cfg;
    logic take;
    logic scan_valid;
    t_run scan_run;
    t_run out_run;

    kcre_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kcre_scan #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_pixel_valid),
        .o_stall     (o_pixel_stall),
        .i_pixel     (i_pixel),
        .i_take      (take),
        .o_run_valid (scan_valid),
        .o_run       (scan_run)
    );

    kcre_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (scan_valid),
        .i_load_run   (scan_run),
        .o_take       (take),
        .o_valid      (o_run_valid),
        .i_stall      (i_run_stall),
        .o_run        (out_run)
    );

    assign o_run_row      = out_run.row;
    assign o_run_start    = out_run.start;
    assign o_run_length   = out_run.length;
    assign o_run_slot     = out_run.slot;
    assign o_run_overflow = out_run.overflow;

endmodule

[tb/key_color_run_extractor_tb.sv]
`timescale 1ns / 1ps

module key_color_run_extractor_tb;
    import kcre_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int LIMIT_NS     = 10_000_000;
    localparam int RANDOM_ITEMS = 380;
    localparam int HOLD_CYCLES  = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_LIMIT = 200_000;
    localparam int MAX_IDLE     = 18;
    localparam int FULL_ROW_W   = 24;

    // index past the register list, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_pixel_valid = 1'b0;
    logic [PIXEL_W-1:0]    i_pixel       = '0;
    logic                  i_run_stall   = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_pixel_stall;
    logic                  o_run_valid;
    logic [COORD_W-1:0]    o_run_row;
    logic [COORD_W-1:0]    o_run_start;
    logic [LENGTH_W-1:0]   o_run_length;
    logic [SLOT_W-1:0]     o_run_slot;
    logic                  o_run_overflow;

    key_color_run_extractor DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_stall  (o_pixel_stall),
        .i_pixel        (i_pixel),
        .o_run_valid    (o_run_valid),
        .i_run_stall    (i_run_stall),
        .o_run_row      (o_run_row),
        .o_run_start    (o_run_start),
        .o_run_length   (o_run_length),
        .o_run_slot     (o_run_slot),
        .o_run_overflow (o_run_overflow)
    );

    // shadow registers and run tracker state
    t_cfg               shadow_cfg = '{key_color: KEY_COLOR_RST, origin_x: '0, origin_y: '0,
                                       window_width: WIDTH_RST, window_height: HEIGHT_RST};
    logic [COORD_W-1:0] col_idx    = '0;
    logic [COORD_W-1:0] row_idx    = '0;
    logic               run_open   = 1'b0;
    logic [COORD_W-1:0] run_origin = '0;
    logic [SLOT_W-1:0]  row_runs   = '0;

    logic [PIXEL_W-1:0] pixel_backlog[$];
    t_run               pending_runs[$];

    int errors       = 0;
    int pixels_sent  = 0;
    int pixels_taken = 0;
    int runs_seen    = 0;
    int tx_idle_max  = 0;
    int rx_idle_max  = 0;
    int tx_wait      = 0;
    int rx_wait      = 0;
    int hold_left    = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, int lim);
        if (v == '0)
            return DIM_W'(1);
        if (v > lim)
            return DIM_W'(lim);
        return v;
    endfunction

    // advance the tracker by one pixel, queue the run it closes if any
    function automatic void track_pixel(logic [PIXEL_W-1:0] px);
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic                hit;
        logic                last_col;
        logic                closed;
        logic [LENGTH_W-1:0] len;
        t_run                run;

        w        = eff_dim(shadow_cfg.window_width, MAX_COLUMNS_DEF);
        h        = eff_dim(shadow_cfg.window_height, MAX_ROWS_DEF);
        hit      = (px == shadow_cfg.key_color);
        last_col = ({1'b0, col_idx} >= w - 1'b1);
        closed   = 1'b0;
        len      = '0;

        if (!run_open) begin
            if (hit) begin
                run_origin = col_idx;
                run_open   = 1'b1;
                if (last_col) begin
                    closed = 1'b1;
                    len    = LENGTH_W'(1);
                end
            end
        end else if (!hit) begin
            closed   = 1'b1;
            len      = LENGTH_W'(col_idx) - LENGTH_W'(run_origin);
            run_open = 1'b0;
        end else if (last_col) begin
            closed = 1'b1;
            len    = LENGTH_W'(col_idx) - LENGTH_W'(run_origin) + LENGTH_W'(1);
        end

        if (closed) begin
            run.row      = shadow_cfg.origin_y + row_idx;
            run.start    = shadow_cfg.origin_x + run_origin;
            run.length   = len;
            run.slot     = row_runs;
            run.overflow = (row_runs >= RUNS_PER_ROW);
            pending_runs.push_back(run);
            if (row_runs != SLOT_MAX)
                row_runs = row_runs + 1'b1;
        end

        if (last_col) begin
            col_idx  = '0;
            run_open = 1'b0;
            row_runs = '0;
            if ({1'b0, row_idx} >= h - 1'b1)
                row_idx = '0;
            else
                row_idx = row_idx + 1'b1;
        end else begin
            col_idx = col_idx + 1'b1;
        end
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t run %s mismatch: expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return MAX_IDLE;
        endcase
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pixel_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_pixel_valid && !o_pixel_stall) begin
                track_pixel(i_pixel);
                pixels_taken++;
                tx_wait = $urandom_range(0, tx_idle_max);
            end
            if (!i_pixel_valid || !o_pixel_stall) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_pixel_valid <= 1'b0;
                end else if (pixel_backlog.size() != 0) begin
                    i_pixel       <= pixel_backlog.pop_front();
                    i_pixel_valid <= 1'b1;
                end else begin
                    i_pixel_valid <= 1'b0;
                end
            end
        end
    end

    // run monitor and receiver stall
    always @(posedge i_clk) begin
        t_run want;
        if (!i_rst_n) begin
            i_run_stall <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
        end else begin
            if (o_run_valid && !i_run_stall) begin
                if (pending_runs.size() == 0) begin
                    errors++;
                    $display("%0t unexpected run: expected none actual row %0d start %0d len %0d",
                             $time, o_run_row, o_run_start, o_run_length);
                end else begin
                    want = pending_runs.pop_front();
                    check_field("row", want.row, o_run_row);
                    check_field("start", want.start, o_run_start);
                    check_field("length", want.length, o_run_length);
                    check_field("slot", want.slot, o_run_slot);
                    check_field("overflow", want.overflow, o_run_overflow);
                end
                runs_seen++;
                rx_wait = $urandom_range(0, rx_idle_max);
                // long back-pressure so the block fills and stalls its input
                if (runs_seen == 25 || runs_seen == 40 || runs_seen == 55)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_run_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_run_stall <= 1'b1;
            end else begin
                i_run_stall <= 1'b0;
            end
        end
    end

    task automatic push_pixel(input logic [PIXEL_W-1:0] px);
        pixel_backlog.push_back(px);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_COLOR:     shadow_cfg.key_color     = value[PIXEL_W-1:0];
            CFG_ORIGIN_X:      shadow_cfg.origin_x      = value[COORD_W-1:0];
            CFG_ORIGIN_Y:      shadow_cfg.origin_y      = value[COORD_W-1:0];
            CFG_WINDOW_WIDTH:  shadow_cfg.window_width  = value[DIM_W-1:0];
            CFG_WINDOW_HEIGHT: shadow_cfg.window_height = value[DIM_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every pixel is taken and every run delivered, then let the pipe drain
    task automatic settle();
        int guard;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while ((pixel_backlog.size() != 0 || pixels_taken != pixels_sent ||
                    pending_runs.size() != 0) && guard < SETTLE_LIMIT);
        if (pending_runs.size() != 0 || pixels_taken != pixels_sent) begin
            errors++;
            $display("%0t stuck: expected %0d more runs actual none, %0d pixels not taken",
                     $time, pending_runs.size(), pixels_sent - pixels_taken);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_origin();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_DATA_W'(2047);
            2:       return CFG_DATA_W'($urandom_range(0, 4095));
            default: return CFG_DATA_W'($urandom_range(0, 2047));
        endcase
    endfunction

    initial begin
        int                 n;
        int                 k;
        int                 len;
        int                 gap;
        int                 pad;
        int                 sent_random;
        bit                 noisy;
        logic [CFG_DATA_W-1:0] value;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry and key color
        tx_idle_max = 0;
        rx_idle_max = 0;
        push_pixel(8'hFF);
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'h00);
        settle();

        // zero width and height act as one, changed mid-row; upper data bits dropped
        write_reg(CFG_KEY_COLOR, 12'hF00);
        write_reg(CFG_ORIGIN_X, 12'd2047);
        write_reg(CFG_ORIGIN_Y, 12'd2047);
        write_reg(CFG_WINDOW_WIDTH, 12'd0);
        write_reg(CFG_WINDOW_HEIGHT, 12'd0);
        write_reg(CFG_IDX_SPARE, 12'h001);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'h00);
        settle();

        // more runs in a row than slots, start column wraps
        write_reg(CFG_KEY_COLOR, 12'h05A);
        write_reg(CFG_ORIGIN_X, 12'd2045);
        write_reg(CFG_ORIGIN_Y, 12'd2046);
        write_reg(CFG_WINDOW_WIDTH, 12'd17);
        write_reg(CFG_WINDOW_HEIGHT, 12'd2);
        tx_idle_max = 3;
        rx_idle_max = 3;
        for (k = 0; k < 17; k++)
            push_pixel(k[0] ? 8'hA5 : 8'h5A);
        settle();

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 4))
                    0:       value = '0;
                    1:       value = CFG_DATA_W'(255);
                    default: value = CFG_DATA_W'($urandom_range(0, 4095));
                endcase
                write_reg(CFG_KEY_COLOR, value);
            end
            if ($urandom_range(0, 1))
                write_reg(CFG_ORIGIN_X, pick_origin());
            if ($urandom_range(0, 1))
                write_reg(CFG_ORIGIN_Y, pick_origin());
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0:       value = '0;
                    1:       value = CFG_DATA_W'(1);
                    2:       value = CFG_DATA_W'($urandom_range(2048, 4095));
                    3:       value = CFG_DATA_W'($urandom_range(21, 300));
                    default: value = CFG_DATA_W'($urandom_range(2, 20));
                endcase
                write_reg(CFG_WINDOW_WIDTH, value);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0:       value = '0;
                    1:       value = CFG_DATA_W'(4095);
                    2:       value = CFG_DATA_W'(2048);
                    default: value = CFG_DATA_W'($urandom_range(1, 5));
                endcase
                write_reg(CFG_WINDOW_HEIGHT, value);
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IDX_SPARE - CFG_IDX_W'($urandom_range(0, 2)),
                          CFG_DATA_W'($urandom_range(0, 4095)));

            tx_idle_max = pick_idle();
            rx_idle_max = pick_idle();
            n     = $urandom_range(20, 60);
            noisy = ($urandom_range(0, 7) == 0);
            k     = 0;
            while (k < n) begin
                if (noisy) begin
                    push_pixel(PIXEL_W'($urandom_range(0, 255)));
                    k++;
                end else begin
                    len = $urandom_range(1, 6);
                    gap = $urandom_range(1, 4);
                    repeat (len) push_pixel(shadow_cfg.key_color);
                    repeat (gap)
                        push_pixel(shadow_cfg.key_color ^ PIXEL_W'($urandom_range(1, 255)));
                    k += len + gap;
                end
            end
            sent_random += k;
            settle();
        end

        // run covering a whole row
        write_reg(CFG_KEY_COLOR, 12'h0C3);
        write_reg(CFG_ORIGIN_X, 12'd0);
        write_reg(CFG_ORIGIN_Y, 12'd1000);
        write_reg(CFG_WINDOW_WIDTH, CFG_DATA_W'(FULL_ROW_W));
        write_reg(CFG_WINDOW_HEIGHT, 12'd2048);
        tx_idle_max = 2;
        rx_idle_max = 2;
        pad = (int'(col_idx) >= FULL_ROW_W - 1) ? 1 : FULL_ROW_W - int'(col_idx);
        repeat (pad) push_pixel(8'h3C);
        repeat (FULL_ROW_W) push_pixel(8'hC3);
        settle();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
